// ----- rtl/core/asp_pkg.sv -----
package asp_pkg;

   // default sizing
   localparam int MaxPhasesDef    = 16;
   localparam int WindowDepthDef  = 8;
   localparam int DurationBitsDef = 12;

   // fixed field widths of the ports
   localparam int SampleBits  = 8;
   localparam int PhaseOutBits = 4;
   localparam int DurOutBits  = 12;
   localparam int CsrIdxBits  = 3;
   localparam int CsrDataBits = 8;

   // request operations
   localparam logic OpLoad   = 1'b0;
   localparam logic OpSwitch = 1'b1;

   // control register indexes
   localparam logic [CsrIdxBits-1:0] CsrPhaseCount    = 3'd0;
   localparam logic [CsrIdxBits-1:0] CsrDecideHorizon = 3'd1;
   localparam logic [CsrIdxBits-1:0] CsrLearnHorizon  = 3'd2;
   localparam logic [CsrIdxBits-1:0] CsrDeltaLimit    = 3'd3;
   localparam logic [CsrIdxBits-1:0] CsrStartPhase    = 3'd4;

   // phase table access strobes
   typedef struct packed {
      logic rd_en;
      logic dur_we;
      logic attr_we;
      logic win_we;
   } pm_cmd_type;

endpackage

// ----- rtl/core/asp_phase_mem.sv -----
module asp_phase_mem import asp_pkg::*; #(
   parameter int MAX_PHASES    = MaxPhasesDef,
   parameter int WINDOW_DEPTH  = WindowDepthDef,
   parameter int DURATION_BITS = DurationBitsDef,
   localparam int PW = $clog2(MAX_PHASES),
   localparam int FW = $clog2(WINDOW_DEPTH + 1),
   localparam int WB = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
   localparam int SW = $clog2(255 * WINDOW_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pm_cmd_type               cmd,
   input  logic [PW-1:0]            rd_addr,
   input  logic [PW-1:0]            wr_addr,
   input  logic [DURATION_BITS-1:0] wr_dur,
   input  logic [DURATION_BITS-1:0] wr_min,
   input  logic [DURATION_BITS-1:0] wr_max,
   input  logic                     wr_green,
   input  logic [FW-1:0]            wr_fill,
   input  logic [WB-1:0]            wr_head,
   input  logic [SW-1:0]            wr_sum,
   output logic [DURATION_BITS-1:0] rd_dur,
   output logic [DURATION_BITS-1:0] rd_min,
   output logic [DURATION_BITS-1:0] rd_max,
   output logic                     rd_green,
   output logic [FW-1:0]            rd_fill,
   output logic [WB-1:0]            rd_head,
   output logic [SW-1:0]            rd_sum
);

   logic [DURATION_BITS-1:0] dur_mem [MAX_PHASES];
   logic [DURATION_BITS-1:0] min_mem [MAX_PHASES];
   logic [DURATION_BITS-1:0] max_mem [MAX_PHASES];
   logic                     green_mem [MAX_PHASES];
   logic [FW-1:0]            fill_mem [MAX_PHASES];
   logic [WB-1:0]            head_mem [MAX_PHASES];
   logic [SW-1:0]            sum_mem [MAX_PHASES];

   logic [MAX_PHASES-1:0]    attr_vld_ff;
   logic [MAX_PHASES-1:0]    win_vld_ff;
   logic                     rd_attr_vld_ff;
   logic                     rd_win_vld_ff;
   logic [DURATION_BITS-1:0] rd_dur_ff;
   logic [DURATION_BITS-1:0] rd_min_ff;
   logic [DURATION_BITS-1:0] rd_max_ff;
   logic                     rd_green_ff;
   logic [FW-1:0]            rd_fill_ff;
   logic [WB-1:0]            rd_head_ff;
   logic [SW-1:0]            rd_sum_ff;

   // write ports and registered read
   always_ff @(posedge clock) begin
      if (cmd.dur_we) begin
         dur_mem[wr_addr] <= wr_dur;
      end
      if (cmd.attr_we) begin
         min_mem[wr_addr]   <= wr_min;
         max_mem[wr_addr]   <= wr_max;
         green_mem[wr_addr] <= wr_green;
      end
      if (cmd.win_we) begin
         fill_mem[wr_addr] <= wr_fill;
         head_mem[wr_addr] <= wr_head;
         sum_mem[wr_addr]  <= wr_sum;
      end
      if (cmd.rd_en) begin
         rd_dur_ff   <= dur_mem[rd_addr];
         rd_min_ff   <= min_mem[rd_addr];
         rd_max_ff   <= max_mem[rd_addr];
         rd_green_ff <= green_mem[rd_addr];
         rd_fill_ff  <= fill_mem[rd_addr];
         rd_head_ff  <= head_mem[rd_addr];
         rd_sum_ff   <= sum_mem[rd_addr];
      end
   end

   // track entries holding defined green flag and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_vld_ff    <= '0;
         win_vld_ff     <= '0;
         rd_attr_vld_ff <= 1'b0;
         rd_win_vld_ff  <= 1'b0;
      end else begin
         if (cmd.attr_we) begin
            attr_vld_ff[wr_addr] <= 1'b1;
         end
         if (cmd.win_we) begin
            win_vld_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_attr_vld_ff <= attr_vld_ff[rd_addr];
            rd_win_vld_ff  <= win_vld_ff[rd_addr];
         end
      end
   end

   // green flag and window state of entries never written read as cleared
   assign rd_dur   = rd_dur_ff;
   assign rd_min   = rd_min_ff;
   assign rd_max   = rd_max_ff;
   assign rd_green = rd_green_ff & rd_attr_vld_ff;
   assign rd_fill  = rd_win_vld_ff ? rd_fill_ff : '0;
   assign rd_head  = rd_win_vld_ff ? rd_head_ff : '0;
   assign rd_sum   = rd_win_vld_ff ? rd_sum_ff : '0;

endmodule

// ----- rtl/core/asp_sample_mem.sv -----
module asp_sample_mem import asp_pkg::*; #(
   parameter int MAX_PHASES   = MaxPhasesDef,
   parameter int WINDOW_DEPTH = WindowDepthDef,
   localparam int WB = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
   localparam int AW = $clog2(MAX_PHASES) + WB
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [SampleBits-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [SampleBits-1:0] rd_data
);

   logic [SampleBits-1:0] smp_mem [MAX_PHASES << WB];
   logic [SampleBits-1:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         smp_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= smp_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/adaptive_signal_phase_timer_top.sv -----
// Adaptive signal phase sequencer. A load request writes one phase entry and
// returns its index and duration through the result registers and then the
// output register; the next request is taken once the response is handed to
// the output register. A switch request ends the current phase, records the
// queue sample in that phase's window when the phase is green, may move one
// second of green time between phases, and steps to the next phase with
// nonzero duration, or flags that none is runnable. The redistribution scan
// visits all phase_count entries, phase_count here being the clamped count;
// it and the zero-skip walk visit one entry at a time through the single
// read port of the phase table. One request is in flight at a time; a
// finished response waits in an output register while the next request is
// taken. No clearing pass runs after reset.
module adaptive_signal_phase_timer_top import asp_pkg::*; #(
   parameter int MAX_PHASES    = MaxPhasesDef,
   parameter int WINDOW_DEPTH  = WindowDepthDef,
   parameter int DURATION_BITS = DurationBitsDef
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic [3:0]             req_phase_index,
   input  logic [11:0]            req_load_duration,
   input  logic [11:0]            req_load_min_duration,
   input  logic [11:0]            req_load_max_duration,
   input  logic                   req_load_is_green,
   input  logic [SampleBits-1:0]  req_queue_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PhaseOutBits-1:0] rsp_next_phase,
   output logic [DurOutBits-1:0]  rsp_next_duration,
   output logic                   rsp_timing_adjusted,
   output logic                   rsp_no_runnable_phase,
   input  logic                   csr_we,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0] csr_wdata
);

   localparam int PW = $clog2(MAX_PHASES);
   localparam int CW = $clog2(MAX_PHASES + 1);
   localparam int FW = $clog2(WINDOW_DEPTH + 1);
   localparam int WB = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int OW = $clog2(2 * WINDOW_DEPTH + 1);
   localparam int SW = $clog2(255 * WINDOW_DEPTH + 1);
   localparam int PD = SW + FW;
   localparam int DB = DURATION_BITS;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_RD    = 12'b0000_0000_0010,
      ST_PUSH  = 12'b0000_0000_0100,
      ST_SCANA = 12'b0000_0000_1000,
      ST_SCANB = 12'b0000_0001_0000,
      ST_SCANC = 12'b0000_0010_0000,
      ST_DEC1  = 12'b0000_0100_0000,
      ST_DEC2  = 12'b0000_1000_0000,
      ST_DEC3  = 12'b0001_0000_0000,
      ST_ADV   = 12'b0010_0000_0000,
      ST_CHK   = 12'b0100_0000_0000,
      ST_OUT   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]            pc_ff, pc_in;
   logic [7:0]            hz_ff, hz_in;
   logic [3:0]            lh_ff, lh_in;
   logic [7:0]            dl_ff, dl_in;
   logic [PW-1:0]         cur_ff, cur_in;
   logic [15:0]           cyc_ff, cyc_in;
   logic [PW-1:0]         last_ff, last_in;
   logic [PW-1:0]         p_ff, p_in;
   logic [SampleBits-1:0] smp_ff, smp_in;
   logic                  drop_ff, drop_in;
   logic [FW-1:0]         wfill_ff, wfill_in;
   logic [WB-1:0]         whead_ff, whead_in;
   logic [SW-1:0]         wsum_ff, wsum_in;
   logic [CW-1:0]         i_ff, i_in;
   logic [CW-1:0]         k_ff, k_in;
   logic                  gf_ff, gf_in;
   logic [PW-1:0]         gi_ff, gi_in;
   logic [SW-1:0]         gs_ff, gs_in;
   logic [FW-1:0]         gc_ff, gc_in;
   logic [DB-1:0]         gd_ff, gd_in;
   logic                  lf_ff, lf_in;
   logic [PW-1:0]         li_ff, li_in;
   logic [SW-1:0]         ls_ff, ls_in;
   logic [FW-1:0]         lc_ff, lc_in;
   logic [DB-1:0]         ld_ff, ld_in;
   logic [PD-1:0]         a_ff, a_in;
   logic [PD-1:0]         b_ff, b_in;
   logic                  adj_ff, adj_in;
   logic [PhaseOutBits-1:0] res_phase_ff, res_phase_in;
   logic [DurOutBits-1:0] res_dur_ff, res_dur_in;
   logic                  res_adj_ff, res_adj_in;
   logic                  res_norun_ff, res_norun_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PhaseOutBits-1:0] rsp_phase_ff, rsp_phase_in;
   logic [DurOutBits-1:0] rsp_dur_ff, rsp_dur_in;
   logic                  rsp_adj_ff, rsp_adj_in;
   logic                  rsp_norun_ff, rsp_norun_in;

   pm_cmd_type            pm_cmd;
   logic [PW-1:0]         pm_rd_addr;
   logic [PW-1:0]         pm_wr_addr;
   logic [DB-1:0]         pm_wr_dur;
   logic [FW-1:0]         pm_wr_fill;
   logic [WB-1:0]         pm_wr_head;
   logic [SW-1:0]         pm_wr_sum;
   logic [DB-1:0]         rd_dur;
   logic [DB-1:0]         rd_min;
   logic [DB-1:0]         rd_max;
   logic                  rd_green;
   logic [FW-1:0]         rd_fill;
   logic [WB-1:0]         rd_head;
   logic [SW-1:0]         rd_sum;

   logic                  sm_wr_en;
   logic                  sm_rd_en;
   logic [PW+WB-1:0]      sm_wr_addr;
   logic [PW+WB-1:0]      sm_rd_addr;
   logic [SampleBits-1:0] sm_rd_data;

   logic [CW-1:0]         cnt;
   logic [FW-1:0]         lhn;
   logic [OW-1:0]         oldest;
   logic [CW-1:0]         step_nxt;
   logic                  req_take;

   // clamped phase count and window length
   always_comb begin
      if (pc_ff == 5'd0) begin
         cnt = CW'(1);
      end else if (32'(pc_ff) > MAX_PHASES) begin
         cnt = CW'(MAX_PHASES);
      end else begin
         cnt = CW'(pc_ff);
      end
      if (lh_ff == 4'd0) begin
         lhn = FW'(1);
      end else if (32'(lh_ff) > WINDOW_DEPTH) begin
         lhn = FW'(WINDOW_DEPTH);
      end else begin
         lhn = FW'(lh_ff);
      end
   end

   // oldest window slot and next step index
   always_comb begin
      oldest = OW'(rd_head) + OW'(WINDOW_DEPTH) - OW'(rd_fill);
      if (32'(oldest) >= WINDOW_DEPTH) begin
         oldest = oldest - OW'(WINDOW_DEPTH);
      end
      step_nxt = CW'(cur_ff) + CW'(1);
      if (step_nxt >= cnt) begin
         step_nxt = '0;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid & req_ready;

   // sequencer
   always_comb begin
      logic [OW-1:0] hnx;
      logic [PD-1:0] lhs;
      logic [PD-1:0] rhs;
      logic [PD+7:0] dgap;
      logic [PD+7:0] dlim;

      state_in     = state_ff;
      pc_in        = pc_ff;
      hz_in        = hz_ff;
      lh_in        = lh_ff;
      dl_in        = dl_ff;
      cur_in       = cur_ff;
      cyc_in       = cyc_ff;
      last_in      = last_ff;
      p_in         = p_ff;
      smp_in       = smp_ff;
      drop_in      = drop_ff;
      wfill_in     = wfill_ff;
      whead_in     = whead_ff;
      wsum_in      = wsum_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      gf_in        = gf_ff;
      gi_in        = gi_ff;
      gs_in        = gs_ff;
      gc_in        = gc_ff;
      gd_in        = gd_ff;
      lf_in        = lf_ff;
      li_in        = li_ff;
      ls_in        = ls_ff;
      lc_in        = lc_ff;
      ld_in        = ld_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      adj_in       = adj_ff;
      res_phase_in = res_phase_ff;
      res_dur_in   = res_dur_ff;
      res_adj_in   = res_adj_ff;
      res_norun_in = res_norun_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_phase_in = rsp_phase_ff;
      rsp_dur_in   = rsp_dur_ff;
      rsp_adj_in   = rsp_adj_ff;
      rsp_norun_in = rsp_norun_ff;

      pm_cmd       = '0;
      pm_rd_addr   = cur_ff;
      pm_wr_addr   = p_ff;
      pm_wr_dur    = DB'(req_load_duration);
      pm_wr_fill   = wfill_ff;
      pm_wr_head   = whead_ff;
      pm_wr_sum    = wsum_ff;
      sm_wr_en     = 1'b0;
      sm_rd_en     = 1'b0;
      sm_wr_addr   = {p_ff, whead_ff};
      sm_rd_addr   = {p_ff, WB'(oldest)};

      hnx  = OW'(whead_ff) + OW'(1);
      lhs  = '0;
      rhs  = '0;
      dgap = '0;
      dlim = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_operation == OpLoad) begin
                  // write the entry and echo it
                  res_phase_in = req_phase_index;
                  res_adj_in   = 1'b0;
                  res_norun_in = 1'b0;
                  res_dur_in   = '0;
                  if (32'(req_phase_index) < MAX_PHASES) begin
                     pm_cmd.dur_we  = 1'b1;
                     pm_cmd.attr_we = 1'b1;
                     pm_wr_addr     = PW'(req_phase_index);
                     res_dur_in     = DurOutBits'(DB'(req_load_duration));
                  end
                  state_in = ST_OUT;
               end else begin
                  // read the ending phase
                  pm_cmd.rd_en = 1'b1;
                  pm_rd_addr   = cur_ff;
                  p_in         = cur_ff;
                  smp_in       = req_queue_sample;
                  adj_in       = 1'b0;
                  k_in         = CW'(1);
                  state_in     = ST_RD;
               end
            end
         end
         ST_RD: begin
            wfill_in = rd_fill;
            whead_in = rd_head;
            wsum_in  = rd_sum;
            drop_in  = (rd_fill >= lhn) && (rd_fill != '0);
            if (rd_green) begin
               // fetch the sample that falls out of the window
               sm_rd_en = 1'b1;
               state_in = ST_PUSH;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_PUSH: begin
            // update window state and store the new sample
            pm_cmd.win_we = 1'b1;
            pm_wr_addr    = p_ff;
            pm_wr_sum     = wsum_ff - (drop_ff ? SW'(sm_rd_data) : SW'(0)) + SW'(smp_ff);
            pm_wr_fill    = wfill_ff - FW'(drop_ff) + FW'(1);
            pm_wr_head    = (32'(hnx) == WINDOW_DEPTH) ? '0 : WB'(hnx);
            sm_wr_en      = 1'b1;
            gf_in         = 1'b0;
            lf_in         = 1'b0;
            i_in          = '0;
            if (16'(hz_ff) <= cyc_ff) begin
               state_in = ST_SCANA;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_SCANA: begin
            pm_cmd.rd_en = 1'b1;
            pm_rd_addr   = i_ff[PW-1:0];
            state_in     = ST_SCANB;
         end
         ST_SCANB: begin
            // gaining candidate: highest mean below its maximum
            lhs = PD'(rd_sum) * PD'(gc_ff);
            rhs = PD'(gs_ff) * PD'(rd_fill);
            if (rd_fill != '0 && rd_dur < rd_max && (!gf_ff || lhs > rhs)) begin
               gf_in = 1'b1;
               gi_in = i_ff[PW-1:0];
               gs_in = rd_sum;
               gc_in = rd_fill;
               gd_in = rd_dur;
            end
            state_in = ST_SCANC;
         end
         ST_SCANC: begin
            // losing candidate: lowest mean above its minimum
            lhs = PD'(rd_sum) * PD'(lc_ff);
            rhs = PD'(ls_ff) * PD'(rd_fill);
            if (rd_fill != '0 && rd_dur > rd_min && (!lf_ff || lhs < rhs)) begin
               lf_in = 1'b1;
               li_in = i_ff[PW-1:0];
               ls_in = rd_sum;
               lc_in = rd_fill;
               ld_in = rd_dur;
            end
            i_in = i_ff + CW'(1);
            if (i_ff + CW'(1) == cnt) begin
               state_in = ST_DEC1;
            end else begin
               state_in = ST_SCANA;
            end
         end
         ST_DEC1: begin
            if (!gf_ff || !lf_ff || gi_ff == li_ff || gs_ff == '0) begin
               state_in = ST_ADV;
            end else begin
               a_in     = PD'(lc_ff) * PD'(gs_ff);
               b_in     = PD'(ls_ff) * PD'(gc_ff);
               state_in = ST_DEC2;
            end
         end
         ST_DEC2: begin
            // relative gap against the limit
            dgap = {a_ff - b_ff, 8'd0};
            dlim = (PD+8)'(dl_ff) * (PD+8)'(a_ff);
            if (a_ff > b_ff && dgap > dlim) begin
               pm_cmd.dur_we = 1'b1;
               pm_wr_addr    = gi_ff;
               pm_wr_dur     = gd_ff + DB'(1);
               adj_in        = 1'b1;
               cyc_in        = '0;
               last_in       = p_ff;
               state_in      = ST_DEC3;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_DEC3: begin
            pm_cmd.dur_we = 1'b1;
            pm_wr_addr    = li_ff;
            pm_wr_dur     = ld_ff - DB'(1);
            state_in      = ST_ADV;
         end
         ST_ADV: begin
            // step and fetch the new phase duration
            pm_cmd.rd_en = 1'b1;
            pm_rd_addr   = PW'(step_nxt);
            cur_in       = PW'(step_nxt);
            if (PW'(step_nxt) == last_ff && cyc_ff != 16'hFFFF) begin
               cyc_in = cyc_ff + 16'd1;
            end
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (rd_dur == '0 && k_ff < cnt) begin
               k_in     = k_ff + CW'(1);
               state_in = ST_ADV;
            end else begin
               res_phase_in = PhaseOutBits'(cur_ff);
               res_dur_in   = DurOutBits'(rd_dur);
               res_adj_in   = adj_ff;
               res_norun_in = (rd_dur == '0);
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_phase_in = res_phase_ff;
               rsp_dur_in   = res_dur_ff;
               rsp_adj_in   = res_adj_ff;
               rsp_norun_in = res_norun_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // control register writes
      if (csr_we) begin
         case (csr_index)
            CsrPhaseCount:    pc_in = csr_wdata[4:0];
            CsrDecideHorizon: hz_in = csr_wdata;
            CsrLearnHorizon:  lh_in = csr_wdata[3:0];
            CsrDeltaLimit:    dl_in = csr_wdata;
            CsrStartPhase: begin
               cur_in = (32'(csr_wdata[3:0]) < MAX_PHASES) ? PW'(csr_wdata[3:0]) : '0;
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= 5'd4;
         hz_ff        <= 8'd1;
         lh_ff        <= 4'd3;
         dl_ff        <= 8'd26;
         cur_ff       <= '0;
         cyc_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         hz_ff        <= hz_in;
         lh_ff        <= lh_in;
         dl_ff        <= dl_in;
         cur_ff       <= cur_in;
         cyc_ff       <= cyc_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      smp_ff       <= smp_in;
      drop_ff      <= drop_in;
      wfill_ff     <= wfill_in;
      whead_ff     <= whead_in;
      wsum_ff      <= wsum_in;
      i_ff         <= i_in;
      k_ff         <= k_in;
      gf_ff        <= gf_in;
      gi_ff        <= gi_in;
      gs_ff        <= gs_in;
      gc_ff        <= gc_in;
      gd_ff        <= gd_in;
      lf_ff        <= lf_in;
      li_ff        <= li_in;
      ls_ff        <= ls_in;
      lc_ff        <= lc_in;
      ld_ff        <= ld_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      adj_ff       <= adj_in;
      res_phase_ff <= res_phase_in;
      res_dur_ff   <= res_dur_in;
      res_adj_ff   <= res_adj_in;
      res_norun_ff <= res_norun_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_dur_ff   <= rsp_dur_in;
      rsp_adj_ff   <= rsp_adj_in;
      rsp_norun_ff <= rsp_norun_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_next_phase        = rsp_phase_ff;
   assign rsp_next_duration     = rsp_dur_ff;
   assign rsp_timing_adjusted   = rsp_adj_ff;
   assign rsp_no_runnable_phase = rsp_norun_ff;

   asp_phase_mem #(
      .MAX_PHASES    (MAX_PHASES),
      .WINDOW_DEPTH  (WINDOW_DEPTH),
      .DURATION_BITS (DURATION_BITS)
   ) u_phase_mem (
      .clock    (clock),
      .reset    (reset),
      .cmd      (pm_cmd),
      .rd_addr  (pm_rd_addr),
      .wr_addr  (pm_wr_addr),
      .wr_dur   (pm_wr_dur),
      .wr_min   (DB'(req_load_min_duration)),
      .wr_max   (DB'(req_load_max_duration)),
      .wr_green (req_load_is_green),
      .wr_fill  (pm_wr_fill),
      .wr_head  (pm_wr_head),
      .wr_sum   (pm_wr_sum),
      .rd_dur   (rd_dur),
      .rd_min   (rd_min),
      .rd_max   (rd_max),
      .rd_green (rd_green),
      .rd_fill  (rd_fill),
      .rd_head  (rd_head),
      .rd_sum   (rd_sum)
   );

   asp_sample_mem #(
      .MAX_PHASES   (MAX_PHASES),
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_sample_mem (
      .clock   (clock),
      .wr_en   (sm_wr_en),
      .wr_addr (sm_wr_addr),
      .wr_data (smp_ff),
      .rd_en   (sm_rd_en),
      .rd_addr (sm_rd_addr),
      .rd_data (sm_rd_data)
   );

endmodule

// ----- rtl/core/asp_checker.sv -----
module asp_checker import asp_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [PhaseOutBits-1:0] rsp_next_phase,
   input logic [DurOutBits-1:0]   rsp_next_duration,
   input logic                    rsp_timing_adjusted,
   input logic                    rsp_no_runnable_phase
);

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // no response right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a phase reported as not runnable has zero duration
   a_norun_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_runnable_phase |-> rsp_next_duration == '0)
      else $error("no runnable phase with nonzero duration");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_phase)
         && $stable(rsp_next_duration) && $stable(rsp_timing_adjusted))
      else $error("stalled response changed");

endmodule

bind adaptive_signal_phase_timer_top asp_checker u_asp_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_next_phase        (rsp_next_phase),
   .rsp_next_duration     (rsp_next_duration),
   .rsp_timing_adjusted   (rsp_timing_adjusted),
   .rsp_no_runnable_phase (rsp_no_runnable_phase)
);

// ----- dv/tb.sv -----
module tb import asp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumPhases   = 16;
   localparam int WinDepth    = 8;
   localparam int RandItems   = 2000;
   localparam int CycleLimit  = 2000000;

   typedef struct packed {
      logic [3:0]  phase;
      logic [11:0] dur;
      logic        adjusted;
      logic        stuck;
   } timing_type;

   typedef struct {
      logic        op;
      logic [3:0]  idx;
      logic [11:0] dur;
      logic [11:0] lo;
      logic [11:0] hi;
      logic        green;
      logic [7:0]  sample;
      bit          typed;
      timing_type  want;
   } stim_row_type;

   logic clock, reset;
   logic req_valid, req_ready, req_operation, req_load_is_green;
   logic [3:0] req_phase_index;
   logic [11:0] req_load_duration, req_load_min_duration, req_load_max_duration;
   logic [SampleBits-1:0] req_queue_sample;
   logic rsp_valid, rsp_ready;
   logic [PhaseOutBits-1:0] rsp_next_phase;
   logic [DurOutBits-1:0] rsp_next_duration;
   logic rsp_timing_adjusted, rsp_no_runnable_phase;
   logic csr_we;
   logic [CsrIdxBits-1:0] csr_index;
   logic [CsrDataBits-1:0] csr_wdata;

   adaptive_signal_phase_timer_top u_dut (.*);

   // shadow phase table and windows
   int unsigned phase_dur[NumPhases], phase_lo[NumPhases], phase_hi[NumPhases];
   bit          phase_grn[NumPhases];
   int unsigned win_buf[NumPhases][WinDepth];
   int unsigned win_fill[NumPhases], win_head[NumPhases], win_sum[NumPhases];
   int unsigned cur_step, since_move, move_step;
   int unsigned cfg_count, cfg_horizon, cfg_learn, cfg_delta;

   timing_type  timing_q[$];
   int          fail_cnt = 0;
   bit          rsp_nostall;
   bit          req_nostall;
   longint      cycles = 0;

   function automatic int unsigned live_count();
      if (cfg_count < 1) return 1;
      if (cfg_count > NumPhases) return NumPhases;
      return cfg_count;
   endfunction

   function automatic void add_sample(int unsigned p, int unsigned s);
      int unsigned n, oldest;
      n = (cfg_learn < 1) ? 1 : (cfg_learn > WinDepth ? WinDepth : cfg_learn);
      if (win_fill[p] >= n && win_fill[p] > 0) begin
         oldest = (win_head[p] + WinDepth - win_fill[p]) % WinDepth;
         win_sum[p] -= win_buf[p][oldest];
         win_fill[p]--;
      end
      win_buf[p][win_head[p]] = s;
      win_head[p] = (win_head[p] + 1) % WinDepth;
      win_sum[p] += s;
      win_fill[p]++;
   endfunction

   // move one second from the lowest-mean phase to the highest-mean phase
   function automatic bit shift_green(int unsigned p);
      int unsigned gi, li;
      bit gf, lf;
      longint s, c, sg, cg, sl, cl;
      gi = 0; li = 0; gf = 0; lf = 0;
      for (int i = 0; i < live_count(); i++) begin
         s = win_sum[i];
         c = win_fill[i];
         if (c == 0) continue;
         if (phase_dur[i] < phase_hi[i])
            if (!gf || s * longint'(win_fill[gi]) > longint'(win_sum[gi]) * c) begin
               gi = i; gf = 1;
            end
         if (phase_dur[i] > phase_lo[i])
            if (!lf || s * longint'(win_fill[li]) < longint'(win_sum[li]) * c) begin
               li = i; lf = 1;
            end
      end
      if (!gf || !lf || gi == li) return 0;
      sg = win_sum[gi]; cg = win_fill[gi];
      sl = win_sum[li]; cl = win_fill[li];
      if (sg == 0) return 0;
      if (!(256 * (cl * sg - sl * cg) > longint'(cfg_delta) * cl * sg)) return 0;
      phase_dur[gi] = (phase_dur[gi] + 1) & 12'hFFF;
      phase_dur[li] = (phase_dur[li] - 1) & 12'hFFF;
      since_move = 0;
      move_step = p;
      return 1;
   endfunction

   function automatic void step_phase();
      cur_step = (cur_step + 1 >= live_count()) ? 0 : cur_step + 1;
      if (cur_step == move_step && since_move < 65535) since_move++;
   endfunction

   function automatic timing_type next_timing(logic op, logic [3:0] idx, logic [11:0] dur,
                                              logic [11:0] lo, logic [11:0] hi,
                                              logic green, logic [7:0] sample);
      timing_type t;
      int unsigned p, k;
      bit adj;
      if (op == OpLoad) begin
         phase_dur[idx] = dur; phase_lo[idx] = lo; phase_hi[idx] = hi;
         phase_grn[idx] = green;
         t = '{phase: idx, dur: dur, adjusted: 1'b0, stuck: 1'b0};
         return t;
      end
      p = cur_step; k = 1; adj = 0;
      if (phase_grn[p]) begin
         add_sample(p, sample);
         if (cfg_horizon <= since_move) adj = shift_green(p);
      end
      step_phase();
      while (phase_dur[cur_step] == 0 && k < live_count()) begin
         step_phase();
         k++;
      end
      t.phase = cur_step[3:0];
      t.dur = phase_dur[cur_step][11:0];
      t.adjusted = adj;
      t.stuck = (phase_dur[cur_step] == 0);
      return t;
   endfunction

   // clock and cycle limit
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("adaptive_signal_phase_timer_top test failed");
         $finish;
      end
   end

   // write one control register; caller drops csr_we after the batch
   task automatic csr_write(logic [CsrIdxBits-1:0] idx, logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CsrPhaseCount:    cfg_count = val & 8'h1F;
         CsrDecideHorizon: cfg_horizon = val;
         CsrLearnHorizon:  cfg_learn = val & 8'h0F;
         CsrDeltaLimit:    cfg_delta = val;
         CsrStartPhase:    cur_step = val & 8'h0F;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // present one request and hold it until accepted
   task automatic send_req(stim_row_type r);
      int gap;
      timing_type t;
      gap = req_nostall ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= r.op;
      req_phase_index <= r.idx;
      req_load_duration <= r.dur;
      req_load_min_duration <= r.lo;
      req_load_max_duration <= r.hi;
      req_load_is_green <= r.green;
      req_queue_sample <= r.sample;
      do @(posedge clock); while (!req_ready);
      t = next_timing(r.op, r.idx, r.dur, r.lo, r.hi, r.green, r.sample);
      timing_q.insert(timing_q.size(), r.typed ? r.want : t);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (timing_q.size() == 0);
      repeat (120) @(negedge clock);
   endtask

   // response side: stall at random, check each response
   initial begin
      timing_type e;
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      wait (!reset);
      forever begin
         gap = rsp_nostall ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (timing_q.size() == 0) begin
            $error("response with no request pending");
            fail_cnt++;
         end else begin
            e = timing_q.pop_front();
            if (rsp_next_phase !== e.phase) begin
               $error("next_phase exp %0d got %0d", e.phase, rsp_next_phase); fail_cnt++;
            end
            if (rsp_next_duration !== e.dur) begin
               $error("next_duration exp %0d got %0d", e.dur, rsp_next_duration); fail_cnt++;
            end
            if (rsp_timing_adjusted !== e.adjusted) begin
               $error("timing_adjusted exp %0d got %0d", e.adjusted, rsp_timing_adjusted);
               fail_cnt++;
            end
            if (rsp_no_runnable_phase !== e.stuck) begin
               $error("no_runnable_phase exp %0d got %0d", e.stuck, rsp_no_runnable_phase);
               fail_cnt++;
            end
         end
         @(negedge clock);
      end
   end

   // main sequence
   initial begin
      stim_row_type tbl[$];
      stim_row_type r;
      int lo;
      req_nostall = 0; rsp_nostall = 0;
      reset = 1'b1; req_valid = 1'b0; req_operation = OpLoad; req_phase_index = '0;
      req_load_duration = '0; req_load_min_duration = '0; req_load_max_duration = '0;
      req_load_is_green = 1'b0; req_queue_sample = '0;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      foreach (phase_dur[i]) begin
         phase_dur[i] = 0; phase_lo[i] = 0; phase_hi[i] = 0; phase_grn[i] = 0;
         win_fill[i] = 0; win_head[i] = 0; win_sum[i] = 0;
         foreach (win_buf[i][j]) win_buf[i][j] = 0;
      end
      cur_step = 0; since_move = 0; move_step = 0;
      cfg_count = 4; cfg_horizon = 1; cfg_learn = 3; cfg_delta = 26;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: fill every entry with zero length, hit all-zero, then reload
      for (int i = 0; i < NumPhases; i++) begin
         r = '{op: OpLoad, idx: 4'(i), dur: 0, lo: (i == 15) ? 12'hFFF : 12'd0,
               hi: (i == 15) ? 12'hFFF : 12'd0, green: i[0], sample: 0, typed: 1,
               want: '{phase: 4'(i), dur: 0, adjusted: 0, stuck: 0}};
         tbl.insert(tbl.size(), r);
      end
      r = '{op: OpSwitch, idx: 0, dur: 0, lo: 0, hi: 0, green: 0, sample: 8'hFF,
            typed: 0, want: '0};
      tbl.insert(tbl.size(), r);
      r.op = OpLoad; r.typed = 1; r.green = 1; r.lo = 0; r.hi = 12'hFFF;
      r.idx = 0; r.dur = 12'hFFF; r.want = '{phase: 0, dur: 12'hFFF, adjusted: 0, stuck: 0};
      tbl.insert(tbl.size(), r);
      r.idx = 1; r.dur = 10; r.want = '{phase: 1, dur: 10, adjusted: 0, stuck: 0};
      tbl.insert(tbl.size(), r);
      r.idx = 2; r.dur = 1; r.green = 0; r.want = '{phase: 2, dur: 1, adjusted: 0, stuck: 0};
      tbl.insert(tbl.size(), r);
      r.idx = 3; r.dur = 5; r.lo = 4; r.hi = 6; r.green = 1;
      r.want = '{phase: 3, dur: 5, adjusted: 0, stuck: 0};
      tbl.insert(tbl.size(), r);
      for (int i = 0; i < 5; i++) begin
         r = '{op: OpSwitch, idx: 0, dur: 0, lo: 0, hi: 0, green: 0,
               sample: 0, typed: 0, want: '0};
         r.sample = (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : (i == 2) ? 8'hC8 :
                    (i == 3) ? 8'h03 : 8'h80;
         tbl.insert(tbl.size(), r);
      end
      foreach (tbl[i]) send_req(tbl[i]);
      drain();

      // random phases, each with its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CsrPhaseCount, (ph == 0) ? 8'd16 : (ph == 1) ? 8'd0 : (ph == 2) ? 8'd31 :
                   (ph == 3) ? 8'd1 : 8'($urandom_range(0, 255)));
         csr_write(CsrDecideHorizon, (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 :
                   8'($urandom_range(0, 3)));
         csr_write(CsrLearnHorizon, (ph == 0) ? 8'd1 : (ph == 1) ? 8'd8 : (ph == 2) ? 8'd15 :
                   (ph == 3) ? 8'd0 : 8'($urandom_range(0, 255)));
         csr_write(CsrDeltaLimit, (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 :
                   8'($urandom_range(0, 80)));
         csr_write(CsrStartPhase, (ph == 0) ? 8'd15 : (ph == 1) ? 8'd0 :
                   8'($urandom_range(0, 255)));
         csr_we <= 1'b0;
         req_nostall = (ph == 4);
         rsp_nostall = (ph == 4 || ph == 6);
         for (int n = 0; n < RandItems / 8; n++) begin
            r.typed = 0; r.want = '0;
            r.op = ($urandom_range(0, 9) < 7) ? OpSwitch : OpLoad;
            r.idx = 4'($urandom_range(0, 15));
            r.sample = 8'($urandom_range(0, 255));
            r.green = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
               r.dur = 12'($urandom_range(0, 4095));
               r.lo = 12'($urandom_range(0, 4095));
               r.hi = 12'($urandom_range(0, 4095));
            end else begin
               lo = $urandom_range(0, 20);
               r.lo = 12'(lo);
               r.hi = 12'(lo + $urandom_range(0, 20));
               r.dur = ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom_range(0, 45));
            end
            send_req(r);
         end
         drain();
      end

      if (fail_cnt == 0)
         $display("adaptive_signal_phase_timer_top test passed");
      else
         $display("adaptive_signal_phase_timer_top test failed");
      $finish;
   end

endmodule
